### design/max_count_sum_within_limit_core_defines.svh
// ----------------------------------------------------------------------------
// max_count_sum_within_limit_core_defines.svh
// Assertion macros for the max count sum within limit block.
// ----------------------------------------------------------------------------
`ifndef MAX_COUNT_SUM_WITHIN_LIMIT_CORE_DEFINES_SVH
`define MAX_COUNT_SUM_WITHIN_LIMIT_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MCSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MCSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mcsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_pkg
// Shared sizes and types for the max count sum within limit block.
// ----------------------------------------------------------------------------
package mcsl_pkg;

  localparam int MAX_ITEMS = 128;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W     = DATA_W + CNT_W;
  localparam int OUT_W     = 8;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [ADDR_W-1:0] addr_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [OUT_W-1:0]  out_cnt_t;

endpackage

### design/mcsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_if
// Valid/ready stream interfaces for item input and count result.
// ----------------------------------------------------------------------------
interface mcsl_in_if;
  import mcsl_pkg::*;

  logic  valid;
  logic  ready;
  data_t item_value;
  logic  last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface mcsl_out_if;
  import mcsl_pkg::*;

  logic     valid;
  logic     ready;
  out_cnt_t element_count;

  modport source (output valid, output element_count, input ready);
  modport sink   (input valid, input element_count, output ready);
endinterface

### design/mcsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mcsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/max_count_sum_within_limit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_count_sum_within_limit_core
// Sorts a data set into a RAM and counts the smallest items within a limit.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   : one signed 32-bit value per transfer; last_item closes the set.
//   result_o : one element_count per closed set, the number of smallest
//              values whose running sum stays at or below the limit.
//   cfg_we_i / cfg_wdata_i : writes the signed limit; write only when idle.
// Timing:
//   An item is inserted by walking the sorted RAM from the top, one entry
//   per cycle through the separate read and write ports, shifting each
//   stored value greater than the item up one place.
//   A closing item adds a setup step, then a scan of the summed entries
//   (one 40-bit add and compare each), then a step to load the result.
//   Items beyond 128 per set are dropped; the set still closes on last_item.
// Reset: limit is 0, the set is empty, no result is pending.
// Stall: the result sits in an output register; a new set can be loaded
//   while it waits, and the next result is held back until it is taken.
// ----------------------------------------------------------------------------
module max_count_sum_within_limit_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  mcsl_pkg::data_t cfg_wdata_i,
  mcsl_in_if.sink         item_i,
  mcsl_out_if.source      result_o
);
  import mcsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_SCAN_RD,
    S_SCAN_ADD,
    S_RESULT
  } state_e;

  state_e   state_q, state_d;
  data_t    limit_q;
  cnt_t     count_q, count_d;
  cnt_t     pos_q, pos_d;
  cnt_t     idx_q, idx_d;
  cnt_t     res_q, res_d;
  sum_t     sum_q, sum_d;
  data_t    val_q, val_d;
  logic     last_q, last_d;
  logic     out_valid_q, out_valid_d;
  out_cnt_t out_count_q, out_count_d;

  logic  ram_we;
  addr_t ram_waddr;
  addr_t ram_raddr;
  data_t ram_wdata;
  data_t ram_rdata;

  logic  in_xfer;
  cnt_t  pos_m1, pos_m2, cnt_m1, idx_p1;
  sum_t  sum_nx;
  sum_t  limit_x;

  mcsl_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign item_i.ready           = (state_q == S_IDLE);
  assign in_xfer                = item_i.valid && item_i.ready;
  assign result_o.valid         = out_valid_q;
  assign result_o.element_count = out_count_q;

  assign pos_m1  = pos_q - cnt_t'(1);
  assign pos_m2  = pos_q - cnt_t'(2);
  assign cnt_m1  = count_q - cnt_t'(1);
  assign idx_p1  = idx_q + cnt_t'(1);
  assign sum_nx  = sum_q + sum_t'(ram_rdata);
  assign limit_x = sum_t'(limit_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    res_d       = res_q;
    sum_d       = sum_q;
    val_d       = val_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_count_d = out_count_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[ADDR_W-1:0];
    ram_wdata   = val_q;
    ram_raddr   = pos_m1[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          val_d  = item_i.item_value;
          last_d = item_i.last_item;
          pos_d  = count_q;
          if (count_q == cnt_t'(MAX_ITEMS)) begin
            state_d = item_i.last_item ? S_SCAN_RD : S_IDLE;
          end else if (count_q == '0) begin
            state_d = S_INS;
          end else begin
            ram_raddr = cnt_m1[ADDR_W-1:0];
            state_d   = S_CMP;
          end
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        if (val_q < ram_rdata) begin
          // shift the larger entry up one place, fetch the next one down
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          ram_raddr = pos_m2[ADDR_W-1:0];
          if (pos_q == cnt_t'(1)) begin
            state_d = S_INS;
          end
        end else begin
          count_d = count_q + cnt_t'(1);
          state_d = last_q ? S_SCAN_RD : S_IDLE;
        end
      end
      S_INS: begin
        ram_we  = 1'b1;
        count_d = count_q + cnt_t'(1);
        state_d = last_q ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        ram_raddr = '0;
        idx_d     = '0;
        sum_d     = '0;
        state_d   = S_SCAN_ADD;
      end
      S_SCAN_ADD: begin
        if (sum_nx > limit_x) begin
          res_d   = idx_q;
          state_d = S_RESULT;
        end else if (idx_p1 == count_q) begin
          res_d   = count_q;
          state_d = S_RESULT;
        end else begin
          idx_d     = idx_p1;
          sum_d     = sum_nx;
          ram_raddr = idx_p1[ADDR_W-1:0];
        end
      end
      S_RESULT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_count_d = OUT_W'(res_q);
          count_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    res_q       <= res_d;
    sum_q       <= sum_d;
    val_q       <= val_d;
    out_count_q <= out_count_d;
  end

endmodule

### design/mcsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsl_checker
// Port-level assertions for the max count sum within limit block.
// ----------------------------------------------------------------------------
`include "max_count_sum_within_limit_core_defines.svh"

module mcsl_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_last_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input mcsl_pkg::out_cnt_t       out_count_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // closing transfer starts the scan, input must stall
  `MCSL_ASSERT_NEXT(a_busy_after_last, in_xfer && in_last_i, !in_ready_i, "ready after last")

  // a result is loaded only from the busy result step
  `MCSL_ASSERT_IMP(a_result_when_busy, $rose(out_valid_i), !$past(in_ready_i), "result while idle")

  // no result can appear right after the closing transfer
  `MCSL_ASSERT_NEXT(a_no_early_result, in_xfer && in_last_i, !$rose(out_valid_i), "early result")

  `MCSL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_count_i), "result dropped")

endmodule

bind max_count_sum_within_limit_core mcsl_checker u_mcsl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (item_i.valid),
  .in_ready_i (item_i.ready),
  .in_last_i  (item_i.last_item),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_count_i(result_o.element_count)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_count_sum_within_limit_core. Data sets are
// streamed in over the item channel, and the limit is changed between
// phases. A sorted-set model predicts each element_count, and every result
// transfer is checked in order against it. Both channels see random idle
// bursts, and one long output hold-off is applied.
// ----------------------------------------------------------------------------
module testbench;
  import mcsl_pkg::*;

  localparam int    SETTLE_CYCLES = 300;
  localparam data_t DATA_MAX      = 32'h7FFF_FFFF;
  localparam data_t DATA_MIN      = 32'h8000_0000;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we;
  data_t cfg_wdata;

  mcsl_in_if  item_if ();
  mcsl_out_if result_if ();

  max_count_sum_within_limit_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // model state
  data_t    sorted_vals[$];
  data_t    limit_val;
  out_cnt_t count_fifo[$];
  int       error_cnt;
  bit       idle_on;
  int       hold_req;
  int       hold_left;
  int       stall_left;

  always #1 clk_i = ~clk_i;

  function automatic void predict_item(data_t v, logic last);
    int     pos;
    int     n;
    longint acc;
    if (sorted_vals.size() < MAX_ITEMS) begin
      pos = sorted_vals.size();
      while (pos > 0 && v < sorted_vals[pos-1]) pos--;
      sorted_vals.insert(pos, v);
    end
    if (last) begin
      acc = 0;
      n   = 0;
      for (int i = 0; i < sorted_vals.size(); i++) begin
        acc += longint'(sorted_vals[i]);
        if (acc > longint'(limit_val)) break;
        n++;
      end
      count_fifo.push_back(out_cnt_t'(n));
      sorted_vals.delete();
    end
  endfunction

  function automatic data_t pick_value(int mode);
    data_t v;
    case (mode)
      0: v = data_t'($urandom);
      1: v = data_t'($urandom_range(200)) - data_t'(100);
      2: v = data_t'($urandom_range(500));
      default: begin
        case ($urandom_range(3))
          0: v = DATA_MAX;
          1: v = DATA_MIN;
          2: v = DATA_MAX - data_t'($urandom_range(15));
          default: v = DATA_MIN + data_t'($urandom_range(15));
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic data_t pick_limit(int phase);
    data_t v;
    case (phase)
      0: v = DATA_MAX;
      1: v = DATA_MIN;
      2: v = '0;
      default: begin
        case ($urandom_range(3))
          0: v = data_t'($urandom);
          1: v = data_t'($urandom_range(3000));
          2: v = -data_t'($urandom_range(300));
          default: v = data_t'($urandom_range(200));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input data_t v, input logic last);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.item_value <= v;
    item_if.last_item  <= last;
    do @(posedge clk_i); while (!item_if.ready);
    predict_item(v, last);
  endtask

  task automatic send_set(input int len, input int mode);
    for (int i = 0; i < len; i++) send_item(pick_value(mode), i == len - 1);
  endtask

  // Sender stops until every pending count is back, then lets the core settle.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (count_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input data_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    limit_val = v;
  endtask

  task automatic test_directed();
    // reset limit of zero
    send_item(32'sd0, 1'b1);
    send_item(32'sd1, 1'b1);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd2, 1'b1);
    send_item(-32'sd1, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd2, 1'b1);
    send_item(DATA_MIN, 1'b0);
    send_item(DATA_MAX, 1'b1);
    write_limit(DATA_MAX);
    send_item(DATA_MAX, 1'b0);
    send_item(DATA_MAX, 1'b0);
    send_item(DATA_MAX, 1'b1);
    send_item(DATA_MIN, 1'b0);
    send_item(DATA_MIN, 1'b0);
    send_item(DATA_MIN, 1'b1);
    write_limit(DATA_MIN);
    send_item(DATA_MIN, 1'b1);
    send_item(-32'sd1, 1'b1);
    send_item(DATA_MIN, 1'b0);
    send_item(-32'sd1, 1'b1);
    write_limit(32'sd100);
    send_item(32'sd50, 1'b0);
    send_item(32'sd60, 1'b0);
    send_item(32'sd40, 1'b1);
  endtask

  task automatic test_full_store();
    write_limit(DATA_MAX);
    for (int i = 0; i < MAX_ITEMS + 2; i++) send_item(data_t'(i), i == MAX_ITEMS + 1);
    write_limit(32'sd2000);
    for (int i = MAX_ITEMS + 1; i > 0; i--) send_item(data_t'(i), i == 1);
    send_set(MAX_ITEMS, 1);
  endtask

  task automatic test_limit_sweep();
    int sent;
    int len;
    for (int phase = 0; phase < 10; phase++) begin
      write_limit(pick_limit(phase));
      sent = 0;
      while (sent < 12) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        send_set(len, $urandom_range(3));
        sent += len;
      end
    end
  endtask

  task automatic test_backpressure();
    write_limit(32'sd150);
    hold_req = 400;
    for (int i = 0; i < 20; i++) send_set($urandom_range(3, 1), 2);
    drain();
  endtask

  task automatic test_no_idle();
    int sent;
    int len;
    idle_on = 1'b0;
    write_limit(pick_limit(3));
    sent = 0;
    while (sent < 100) begin
      len = $urandom_range(10, 1);
      send_set(len, $urandom_range(3));
      sent += len;
    end
  endtask

  // result side: check each transfer, then decide ready for the next cycle
  always @(posedge clk_i) begin
    logic     rdy;
    out_cnt_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (count_fifo.size() == 0) begin
        $display("%0t: unexpected element_count, expected none, actual %0d",
                 $time, result_if.element_count);
        error_cnt++;
      end else begin
        want = count_fifo.pop_front();
        if (result_if.element_count !== want) begin
          $display("%0t: element_count expected %0d, actual %0d",
                   $time, want, result_if.element_count);
          error_cnt++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(16, 1) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    result_if.ready <= rdy;
  end

  initial begin
    #2_000_000;
    $display("max_count_sum_within_limit_core: mismatch");
    $finish;
  end

  initial begin
    item_if.valid      = 1'b0;
    item_if.item_value = '0;
    item_if.last_item  = 1'b0;
    result_if.ready    = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    limit_val          = '0;
    error_cnt          = 0;
    idle_on            = 1'b1;
    hold_req           = 0;
    hold_left          = 0;
    stall_left         = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_limit_sweep();
    test_backpressure();
    test_no_idle();
    drain();
    if (error_cnt == 0 && count_fifo.size() == 0) begin
      $display("max_count_sum_within_limit_core: match");
    end else begin
      $display("max_count_sum_within_limit_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/mcsl_pkg.sv
design/mcsl_if.sv
design/mcsl_ram.sv
design/max_count_sum_within_limit_core.sv
design/mcsl_checker.sv
test/testbench.sv
